>>> src/masked_key_duplicate_table_unit_assert.svh
// Assertion macros used by the duplicate table top level.
`ifndef MASKED_KEY_DUPLICATE_TABLE_UNIT_ASSERT_SVH
`define MASKED_KEY_DUPLICATE_TABLE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MKDT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MKDT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mkdt_pkg.sv
// Package with the types and constants of the duplicate table.
`timescale 1ns / 1ps

package mkdt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int NUM_CELLS   = 4;
    localparam int CELL_DEPTH  = TABLE_DEPTH / NUM_CELLS;
    localparam int CELL_AW     = $clog2(CELL_DEPTH);
    localparam int CELL_IDX_W  = $clog2(NUM_CELLS);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W       = CELL_AW + 1;
    localparam int KEY_W       = 60;
    localparam int TAG_W       = 8;
    localparam int EXCH_W      = 64;

    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [KEY_W-1:0]  call_key;
        logic [TAG_W-1:0]  band_mode;
        logic [TAG_W-1:0]  band_mode_mask;
        logic              need_history;
        logic [EXCH_W-1:0] exchange_value;
    } item_t;

    typedef struct packed {
        logic              is_dupe;
        logic              history_found;
        logic [EXCH_W-1:0] history_exchange;
        logic              table_full;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [EXCH_W-1:0] exch;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic               en;
        logic [CELL_AW-1:0] addr;
        entry_t             entry;
    } wr_t;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [TAG_W-1:0]   tag;
        logic [TAG_W-1:0]   mask;
        logic               want;
        logic               dupe;
        logic               found;
        logic [EXCH_W-1:0]  hist;
        logic [COUNT_W-1:0] left;
    } token_t;

endpackage

>>> src/mkdt_cell.sv
// One cell of the chain: a bank of entries that a query token scans in order.
`timescale 1ns / 1ps

module mkdt_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  mkdt_pkg::wr_t    wr,
    input  mkdt_pkg::token_t tok_in,
    output mkdt_pkg::token_t tok_out
);

    mkdt_pkg::entry_t mem [mkdt_pkg::CELL_DEPTH];

    logic                        active_reg;
    logic                        active_next;
    mkdt_pkg::token_t            acc_reg;
    mkdt_pkg::token_t            acc_next;
    mkdt_pkg::token_t            acc_eval;
    logic [mkdt_pkg::LEN_W-1:0]  len_reg;
    logic [mkdt_pkg::LEN_W-1:0]  len_next;
    logic [mkdt_pkg::LEN_W-1:0]  cnt_reg;
    logic [mkdt_pkg::LEN_W-1:0]  cnt_next;
    logic [mkdt_pkg::LEN_W-1:0]  in_len;
    logic                        pend_reg;
    logic                        pend_next;
    mkdt_pkg::entry_t            rd_data_reg;
    logic [mkdt_pkg::CELL_AW-1:0] rd_addr;
    logic                        out_vld_reg;
    logic                        out_vld_next;
    mkdt_pkg::token_t            out_pay_reg;
    logic                        tag_eq;
    logic                        key_eq;
    logic                        stop;
    logic                        issue;
    logic                        finish;

    always_comb
    begin
        tag_eq   = ((rd_data_reg.tag & acc_reg.mask) == (acc_reg.tag & acc_reg.mask));
        key_eq   = (rd_data_reg.key == acc_reg.key);
        acc_eval = acc_reg;
        if (pend_reg)
        begin
            if (tag_eq)
            begin
                if (key_eq)
                begin
                    acc_eval.dupe = 1'b1;
                end
            end
            else if (acc_reg.want && key_eq)
            begin
                acc_eval.hist  = rd_data_reg.exch;
                acc_eval.found = 1'b1;
                acc_eval.want  = 1'b0;
            end
        end
        stop    = acc_eval.dupe && !acc_eval.want;
        issue   = active_reg && !stop && (cnt_reg < len_reg);
        finish  = active_reg && !issue;
        rd_addr = cnt_reg[mkdt_pkg::CELL_AW-1:0];

        if (tok_in.left >= mkdt_pkg::COUNT_W'(mkdt_pkg::CELL_DEPTH))
        begin
            in_len = mkdt_pkg::LEN_W'(mkdt_pkg::CELL_DEPTH);
        end
        else
        begin
            in_len = tok_in.left[mkdt_pkg::LEN_W-1:0];
        end

        active_next  = active_reg;
        acc_next     = acc_eval;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        pend_next    = issue;
        out_vld_next = finish;
        if (issue)
        begin
            cnt_next = cnt_reg + mkdt_pkg::LEN_W'(1);
        end
        if (finish)
        begin
            active_next = 1'b0;
        end
        if (tok_in.valid)
        begin
            active_next   = 1'b1;
            acc_next      = tok_in;
            acc_next.left = tok_in.left - mkdt_pkg::COUNT_W'(in_len);
            len_next      = in_len;
            cnt_next      = '0;
            pend_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        len_reg     <= len_next;
        cnt_reg     <= cnt_next;
        out_pay_reg <= acc_eval;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        tok_out       = out_pay_reg;
        tok_out.valid = out_vld_reg;
    end

endmodule

>>> src/masked_key_duplicate_table_unit.sv
// Top level of the masked-key duplicate table.
//
// Items enter through start/busy/item: a transfer happens at a clock edge
// with start high and busy low. Each item yields one result on the result
// port, marked by a one-cycle done strobe; the receiver cannot stall it.
// An insert appends one entry and its result appears in the cycle after the
// transfer; busy stays low, so inserts can follow back to back. When the
// table already holds TABLE_DEPTH entries the insert is dropped and
// table_full is set.
// A query passes a token through a chain of NUM_CELLS cells, each owning
// CELL_DEPTH entries in its own memory and scanning one entry per cycle.
// A query reads at most entry_count entries through the one-entry-per-cycle
// read ports of the cell memories; busy is high while the token travels the
// chain and goes low as the done strobe rises.
// The scan ends early once a duplicate is seen and no history is wanted.
// Reset clears the entry count and all control state; the memories are not
// cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps
`include "masked_key_duplicate_table_unit_assert.svh"

module masked_key_duplicate_table_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mkdt_pkg::item_t   item,
    output logic              done,
    output mkdt_pkg::result_t result
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [mkdt_pkg::COUNT_W-1:0]   count_reg;
    logic [mkdt_pkg::COUNT_W-1:0]   count_next;
    logic                           done_reg;
    logic                           done_next;
    mkdt_pkg::result_t              result_reg;
    mkdt_pkg::result_t              result_next;
    logic                           accept;
    logic                           is_full;
    logic [mkdt_pkg::CELL_IDX_W-1:0] bank;
    mkdt_pkg::token_t               chain [mkdt_pkg::NUM_CELLS+1];
    mkdt_pkg::wr_t                  wr_cell [mkdt_pkg::NUM_CELLS];

    assign accept  = start && (state_reg == ST_IDLE);
    assign is_full = (count_reg == mkdt_pkg::COUNT_W'(mkdt_pkg::TABLE_DEPTH));
    assign bank    = count_reg[mkdt_pkg::CELL_AW +: mkdt_pkg::CELL_IDX_W];

    always_comb
    begin
        chain[0].valid = accept && (item.kind == mkdt_pkg::KIND_QUERY);
        chain[0].key   = item.call_key;
        chain[0].tag   = item.band_mode;
        chain[0].mask  = item.band_mode_mask;
        chain[0].want  = item.need_history;
        chain[0].dupe  = 1'b0;
        chain[0].found = 1'b0;
        chain[0].hist  = '0;
        chain[0].left  = count_reg;
    end

    for (genvar k = 0; k < mkdt_pkg::NUM_CELLS; k++)
    begin : g_cell
        always_comb
        begin
            wr_cell[k].en = accept && (item.kind == mkdt_pkg::KIND_INSERT) && !is_full
                            && (bank == mkdt_pkg::CELL_IDX_W'(k));
            wr_cell[k].addr       = count_reg[mkdt_pkg::CELL_AW-1:0];
            wr_cell[k].entry.key  = item.call_key;
            wr_cell[k].entry.exch = item.exchange_value;
            wr_cell[k].entry.tag  = item.band_mode;
        end

        mkdt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr_cell[k]),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.kind == mkdt_pkg::KIND_INSERT)
                    begin
                        done_next                    = 1'b1;
                        result_next.is_dupe          = 1'b0;
                        result_next.history_found    = 1'b0;
                        result_next.history_exchange = '0;
                        result_next.table_full       = is_full;
                        if (!is_full)
                        begin
                            count_next = count_reg + mkdt_pkg::COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (chain[mkdt_pkg::NUM_CELLS].valid)
                begin
                    state_next                   = ST_IDLE;
                    done_next                    = 1'b1;
                    result_next.is_dupe          = chain[mkdt_pkg::NUM_CELLS].dupe;
                    result_next.history_found    = chain[mkdt_pkg::NUM_CELLS].found;
                    result_next.history_exchange = chain[mkdt_pkg::NUM_CELLS].hist;
                    result_next.table_full       = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = (state_reg == ST_SCAN);
    assign done   = done_reg;
    assign result = result_reg;

    `MKDT_ASSERT_IMP(a_count_range, 1'b1,
        count_reg <= mkdt_pkg::COUNT_W'(mkdt_pkg::TABLE_DEPTH), "entry count beyond depth")
    `MKDT_ASSERT_NXT(a_item_progress, start && !busy, done || busy,
        "accepted item neither finished nor scanning")
    `MKDT_ASSERT_NXT(a_token_done, chain[mkdt_pkg::NUM_CELLS].valid, done && !busy,
        "returned token did not produce a result")
    `MKDT_ASSERT_IMP(a_full_excl, done && result.table_full,
        !result.is_dupe && !result.history_found, "full flag mixed with query fields")
    `MKDT_ASSERT_IMP(a_hist_zero, done && !result.history_found,
        result.history_exchange == '0, "history exchange without a history entry")

endmodule
